/* rtl/core/assert_macros.svh */
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every rising clock edge outside reset.
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked at every rising clock edge outside reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

/* rtl/core/mwsr_pkg.sv */
// Types and constants of the mecanum wheel setpoint ramp.
package mwsr_pkg;
    localparam int unsigned NUM_WHEELS = 4;
    localparam int unsigned CMD_W      = 16;
    localparam int unsigned TGT_W      = 18;
    localparam int unsigned OUT_W      = 16;
    localparam int unsigned DIV_W      = 34;
    localparam int unsigned ADDR_W     = 5;

    localparam logic [ADDR_W-1:0] REG_SPEED_LIMIT  = 5'd0;
    localparam logic [ADDR_W-1:0] REG_RAMP_STEP    = 5'd4;
    localparam logic [ADDR_W-1:0] REG_INIT_STEP    = 5'd8;
    localparam logic [ADDR_W-1:0] REG_OMEGA_MAX    = 5'd12;
    localparam logic [ADDR_W-1:0] REG_VELOCITY_MAX = 5'd16;

    typedef struct packed {
        logic signed [CMD_W-1:0] vel_x;
        logic signed [CMD_W-1:0] vel_y;
        logic signed [CMD_W-1:0] vel_rot;
    } t_cmd;

    typedef struct packed {
        logic signed [OUT_W-1:0] omega_front_left;
        logic signed [OUT_W-1:0] omega_front_right;
        logic signed [OUT_W-1:0] omega_rear_right;
        logic signed [OUT_W-1:0] omega_rear_left;
    } t_res;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [DIV_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic              busy;
        logic [DIV_W-1:0]  quotient;
    } t_div_rsp;
endpackage

/* rtl/core/mwsr_stream_if.sv */
// Valid/ready channel interface carrying one payload.
interface mwsr_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/mecanum_wheel_setpoint_ramp.sv */
// Top level of the mecanum wheel setpoint ramp.
// Usage:
// A body velocity command (vel_x, vel_y, vel_rot) is taken on the command
// channel by a valid/ready transfer. The block mixes it into four wheel
// targets, scales them down when one exceeds speed_limit, ramps the held
// wheel velocities and scales each to an omega value.
// One item is worked on at a time. The shared bit-serial divider does four
// divisions for limiting (only when the limit is exceeded) and four for the
// outputs; they follow the mix pass and the ramp pass over the four wheels
// respectively, and the result is then loaded into the output register.
// The result is held in an output register until the sink takes it; the next
// command is accepted in that time and works until it needs that register.
// Reset clears the wheel velocities, the initial phase flag and restores
// register reset values. If the receiver stalls, the result stays stable.
// Registers are written over the APB port at byte addresses 0, 4, 8, 12, 16.
`include "assert_macros.svh"
module mecanum_wheel_setpoint_ramp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    mwsr_stream_if.sink                     i_cmd,
    mwsr_stream_if.source                   o_res,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mwsr_pkg::ADDR_W-1:0]     paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import mwsr_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_MIX, S_LIM_START, S_LIM_WAIT, S_RAMP, S_OUT_START, S_OUT_WAIT, S_PUSH
    } t_state;

    t_state r_state;
    logic [14:0] r_speed_limit, r_omega_max, r_velocity_max;
    logic [11:0] r_ramp_step, r_init_step;
    logic signed [TGT_W-1:0] r_tgt [NUM_WHEELS];
    logic signed [OUT_W-1:0] r_vel [NUM_WHEELS];
    logic signed [OUT_W-1:0] r_omega [NUM_WHEELS];
    logic        r_init_done;
    logic [1:0]  r_idx;
    logic [TGT_W-1:0] r_peak;
    logic        r_neg;
    t_cmd        r_cmd;
    logic        r_out_valid;
    t_res        r_out;
    t_div_req    w_req;
    t_div_rsp    w_rsp;

    logic signed [TGT_W-1:0] w_t;
    logic signed [TGT_W-1:0] w_v;
    logic signed [TGT_W:0]   w_up, w_dn;
    logic [11:0]             w_st;
    logic [TGT_W-1:0]        w_abs;
    logic signed [TGT_W-1:0] w_mix;
    logic signed [TGT_W-1:0] w_sx, w_sy, w_sr;
    logic [DIV_W-1:0]        w_q;
    logic                    w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_comb begin
        case (paddr)
            REG_SPEED_LIMIT:  prdata = {17'd0, r_speed_limit};
            REG_RAMP_STEP:    prdata = {20'd0, r_ramp_step};
            REG_INIT_STEP:    prdata = {20'd0, r_init_step};
            REG_OMEGA_MAX:    prdata = {17'd0, r_omega_max};
            REG_VELOCITY_MAX: prdata = {17'd0, r_velocity_max};
            default:          prdata = '0;
        endcase
    end

    assign w_sx = TGT_W'(r_cmd.vel_x);
    assign w_sy = TGT_W'(r_cmd.vel_y);
    assign w_sr = TGT_W'(r_cmd.vel_rot);

    always_comb begin
        case (r_idx)
            2'd0:    w_mix = w_sx + w_sy + w_sr;
            2'd1:    w_mix = w_sx - w_sy + w_sr;
            2'd2:    w_mix = w_sr - w_sx - w_sy;
            default: w_mix = w_sr - w_sx + w_sy;
        endcase
    end
    assign w_abs = w_mix[TGT_W-1] ? TGT_W'(-w_mix) : w_mix;

    assign w_t  = r_tgt[r_idx];
    assign w_v  = TGT_W'(r_vel[r_idx]);
    assign w_st = r_init_done ? r_ramp_step : r_init_step;
    assign w_up = (TGT_W+1)'(w_v) + (TGT_W+1)'($signed({1'b0, w_st}));
    assign w_dn = (TGT_W+1)'(w_v) - (TGT_W+1)'($signed({1'b0, w_st}));

    always_comb begin
        w_req = '0;
        if (r_state == S_LIM_START) begin
            w_req.start    = 1'b1;
            w_req.dividend = DIV_W'(w_t[TGT_W-1] ? TGT_W'(-w_t) : w_t)
                             * DIV_W'(r_speed_limit);
            w_req.divisor  = DIV_W'(r_peak);
        end else if (r_state == S_OUT_START) begin
            w_req.start    = 1'b1;
            w_req.dividend = DIV_W'(r_vel[r_idx][OUT_W-1] ? 17'(-17'(r_vel[r_idx]))
                                    : 17'(r_vel[r_idx])) * DIV_W'(r_omega_max);
            w_req.divisor  = (r_velocity_max == '0) ? DIV_W'(1) : DIV_W'(r_velocity_max);
        end
    end

    mwsr_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );
    assign w_q = w_rsp.quotient;

    assign i_cmd.ready = (r_state == S_IDLE);
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_speed_limit  <= 15'd1000;
            r_ramp_step    <= 12'd20;
            r_init_step    <= 12'd6;
            r_omega_max    <= 15'd40;
            r_velocity_max <= 15'd1000;
            r_init_done    <= 1'b0;
            r_out_valid    <= 1'b0;
            r_idx          <= '0;
            for (int i = 0; i < NUM_WHEELS; i++) r_vel[i] <= '0;
        end else begin
            if (w_cfg_wr) begin
                case (paddr)
                    REG_SPEED_LIMIT:  r_speed_limit  <= pwdata[14:0];
                    REG_RAMP_STEP:    r_ramp_step    <= pwdata[11:0];
                    REG_INIT_STEP:    r_init_step    <= pwdata[11:0];
                    REG_OMEGA_MAX:    r_omega_max    <= pwdata[14:0];
                    REG_VELOCITY_MAX: r_velocity_max <= pwdata[14:0];
                    default: ;
                endcase
            end
            if (o_res.valid && o_res.ready && r_state != S_PUSH) r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_cmd.valid) begin
                        r_cmd   <= i_cmd.data;
                        r_idx   <= '0;
                        r_peak  <= '0;
                        r_state <= S_MIX;
                    end
                end
                S_MIX: begin
                    r_tgt[r_idx] <= w_mix;
                    if (w_abs > r_peak) r_peak <= w_abs;
                    r_idx <= r_idx + 2'd1;
                    if (r_idx == 2'(NUM_WHEELS - 1)) begin
                        r_state <= ((w_abs > r_peak ? w_abs : r_peak) > TGT_W'(r_speed_limit))
                                   ? S_LIM_START : S_RAMP;
                    end
                end
                S_LIM_START: begin
                    r_neg   <= w_t[TGT_W-1];
                    r_state <= S_LIM_WAIT;
                end
                S_LIM_WAIT: begin
                    if (w_rsp.done) begin
                        r_tgt[r_idx] <= r_neg ? TGT_W'(-$signed(w_q[TGT_W-1:0]))
                                              : $signed(w_q[TGT_W-1:0]);
                        r_idx   <= r_idx + 2'd1;
                        r_state <= (r_idx == 2'(NUM_WHEELS - 1)) ? S_RAMP : S_LIM_START;
                    end
                end
                S_RAMP: begin
                    if (w_v != w_t) begin
                        if (w_up < (TGT_W+1)'(w_t)) begin
                            r_vel[r_idx] <= OUT_W'(w_up);
                        end else if (w_dn > (TGT_W+1)'(w_t)) begin
                            r_vel[r_idx] <= OUT_W'(w_dn);
                        end else begin
                            r_vel[r_idx] <= OUT_W'(w_t);
                            r_init_done  <= 1'b1;
                        end
                    end
                    r_idx <= r_idx + 2'd1;
                    if (r_idx == 2'(NUM_WHEELS - 1)) r_state <= S_OUT_START;
                end
                S_OUT_START: begin
                    r_neg   <= r_vel[r_idx][OUT_W-1];
                    r_state <= S_OUT_WAIT;
                end
                S_OUT_WAIT: begin
                    if (w_rsp.done) begin
                        if (w_q > DIV_W'(32767))
                            r_omega[r_idx] <= r_neg ? OUT_W'(-32768) : OUT_W'(32767);
                        else
                            r_omega[r_idx] <= r_neg ? OUT_W'(-$signed(w_q[OUT_W-1:0]))
                                                    : $signed(w_q[OUT_W-1:0]);
                        r_idx   <= r_idx + 2'd1;
                        r_state <= (r_idx == 2'(NUM_WHEELS - 1)) ? S_PUSH : S_OUT_START;
                    end
                end
                S_PUSH: begin
                    if (!r_out_valid || o_res.ready) begin
                        r_out.omega_front_left  <= r_omega[0];
                        r_out.omega_front_right <= r_omega[1];
                        r_out.omega_rear_right  <= r_omega[2];
                        r_out.omega_rear_left   <= r_omega[3];
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `CHK_NEXT(a_out_stable, i_clk, i_rst_n, o_res.valid && !o_res.ready, o_res.valid && $stable(o_res.data), "result changed while stalled")
    `CHK_IMPL(a_accept_idle, i_clk, i_rst_n, i_cmd.valid && i_cmd.ready, r_state == S_IDLE, "command taken while busy")
    `CHK_NEXT(a_phase_sticky, i_clk, i_rst_n, r_init_done, r_init_done, "initial phase flag cleared")
endmodule

/* rtl/core/mwsr_divider.sv */
// Bit-serial unsigned restoring divider, one quotient bit per cycle.
`include "assert_macros.svh"
module mwsr_divider (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mwsr_pkg::t_div_req  i_req,
    output mwsr_pkg::t_div_rsp  o_rsp
);
    import mwsr_pkg::*;

    logic [DIV_W-1:0] r_quo, n_quo;
    logic [DIV_W-1:0] r_rem, n_rem;
    logic [DIV_W-1:0] r_dvs, n_dvs;
    logic [5:0]       r_cnt, n_cnt;
    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [DIV_W:0]   w_trial;

    always_comb begin
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        w_trial = {r_rem, r_quo[DIV_W-1]} - {1'b0, r_dvs};
        if (i_req.start) begin
            n_quo  = i_req.dividend;
            n_rem  = '0;
            n_dvs  = i_req.divisor;
            n_cnt  = 6'(DIV_W);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (!w_trial[DIV_W]) begin
                n_rem = w_trial[DIV_W-1:0];
                n_quo = {r_quo[DIV_W-2:0], 1'b1};
            end else begin
                n_rem = {r_rem[DIV_W-2:0], r_quo[DIV_W-1]};
                n_quo = {r_quo[DIV_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.busy     = r_busy;
    assign o_rsp.quotient = r_quo;

    `CHK_NEXT(a_div_done_after_last, i_clk, i_rst_n, r_busy && r_cnt == 6'd1 && !i_req.start, r_done && !r_busy, "divider did not finish on its last bit")
    `CHK_IMPL(a_div_done_not_busy, i_clk, i_rst_n, r_done, !r_busy, "divider done while still busy")
    `CHK_NEXT(a_div_start_busy, i_clk, i_rst_n, i_req.start, r_busy, "divider not busy after start")
endmodule
